// ===== rtl/cfp_pkg.sv =====
package cfp_pkg;

  localparam int HEADER_WORDS    = 8;
  localparam int TRAILER_WORDS   = 3;
  localparam int MAX_DATA_BYTES  = 488;
  localparam int MAX_FRAME_WORDS = 255;
  localparam int POS_W           = 9;
  localparam int COUNT_W         = 12;

  localparam logic [POS_W-1:0] POS_MAX  = '1;
  localparam logic [15:0]      CRC_POLY = 16'h8005;

  typedef enum logic [3:0] {
    ROLE_OPCODE     = 4'd0,
    ROLE_COUNT      = 4'd1,
    ROLE_SOURCE     = 4'd2,
    ROLE_DEST_ADDR  = 4'd3,
    ROLE_DEST_IDX   = 4'd4,
    ROLE_SRC_ADDR   = 4'd5,
    ROLE_SRC_IDX    = 4'd6,
    ROLE_ACK        = 4'd7,
    ROLE_DATA       = 4'd8,
    ROLE_CABLE_DEST = 4'd9,
    ROLE_CABLE_SRC  = 4'd10,
    ROLE_CHECK      = 4'd11,
    ROLE_EXCESS     = 4'd12
  } role_t;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_TOO_SHORT  = 3'd1,
    STAT_TOO_LONG   = 3'd2,
    STAT_COUNT_HIGH = 3'd3,
    STAT_LEN_BAD    = 3'd4
  } status_t;

  // Payload of one result transaction, apart from the role and the last flag.
  typedef struct packed {
    status_t              frame_status;
    logic                 crc_match;
    logic                 high_byte_valid;
    logic [7:0]           high_byte;
    logic                 low_byte_valid;
    logic [7:0]           low_byte;
    logic [COUNT_W-1:0]   data_byte_count;
    logic [3:0]           forward_count;
    logic [15:0]          field_value;
  } result_t;

endpackage

// ===== rtl/cfp_crc16.sv =====
module cfp_crc16
  import cfp_pkg::*;
(
  input  logic [15:0] crc_in,
  input  logic [15:0] data_in,
  output logic [15:0] crc_out
);

  // One word through the MSB-first shift register, flattened to XOR logic.
  always_comb begin
    logic [15:0] r;
    logic        fb;
    r = crc_in;
    for (int k = 15; k >= 0; k--) begin
      fb = data_in[k] ^ r[15];
      r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    crc_out = r;
  end

endmodule

// ===== rtl/chaos_frame_parser_crc16.sv =====
// Chaos frame parser with CRC-16 check.
// Input channel: one 16-bit frame word per transaction on in_tdata, with
// in_tlast on the final word of the frame. Result channel: one transaction
// per input word; out_tuser gives the word's role, out_tdata its decoded
// fields, out_tlast marks the result of the final word. On that result
// the CRC match flag and frame_status are valid; a nonzero status means
// drop the frame.
// Each accepted word's result is registered and shows on out_* in the cycle after it is accepted.
// Throughput is one word per cycle: the role decode, status checks and the
// unrolled CRC-16 step all sit between the accepting edge and the single
// result register, and a new word is taken whenever that register is empty
// or being drained in the same cycle.
// When out_tready is low the result is held and in_tready drops until the
// result is taken, so nothing is lost.
// Reset (rst_n low, synchronous) clears the CRC, the word position, the held
// data byte count and the result valid flag.
module chaos_frame_parser_crc16
  import cfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] frame_word
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [15:0] field_value, [19:16] forward_count,
                                  // [31:20] data_byte_count, [39:32] low_byte,
                                  // [40] low_byte_valid, [48:41] high_byte,
                                  // [49] high_byte_valid, [50] crc_match,
                                  // [53:51] frame_status, [55:54] zero
  output logic [3:0]  out_tuser,  // [3:0] word_role
  output logic        out_tlast
);

  logic [15:0]        crc_r, crc_nxt, crc_step;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  role_t              role_r, role_nxt;
  result_t            res_r, res_nxt;
  logic               last_r, last_nxt;

  logic               in_acc;
  logic [COUNT_W-1:0] cnt_use, data_wcnt, trail_idx;
  logic [POS_W-1:0]   rel;
  logic [POS_W:0]     n_words;
  logic               is_data;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  cfp_crc16 u_crc (
    .crc_in  (crc_r),
    .data_in (in_tdata),
    .crc_out (crc_step)
  );

  // Word 1 carries this frame's count; later words use the held copy.
  assign cnt_use    = (pos_r == POS_W'(1)) ? in_tdata[COUNT_W-1:0] : cnt_r;
  assign data_wcnt  = COUNT_W'(({1'b0, cnt_use} + {{COUNT_W{1'b0}}, 1'b1}) >> 1);
  assign rel        = pos_r - POS_W'(HEADER_WORDS);
  assign is_data    = {{(COUNT_W-POS_W){1'b0}}, rel} < data_wcnt;
  assign trail_idx  = {{(COUNT_W-POS_W){1'b0}}, rel} - data_wcnt;
  assign n_words    = {1'b0, pos_r} + {{POS_W{1'b0}}, 1'b1};

  always_comb begin
    role_nxt = ROLE_EXCESS;
    res_nxt  = '0;
    res_nxt.field_value = in_tdata;
    if (pos_r == '0) begin
      role_nxt = ROLE_OPCODE;
      res_nxt.field_value = {8'h00, in_tdata[15:8]};
    end else if (pos_r == POS_W'(1)) begin
      role_nxt = ROLE_COUNT;
      res_nxt.forward_count   = in_tdata[15:12];
      res_nxt.data_byte_count = in_tdata[COUNT_W-1:0];
    end else if (pos_r < POS_W'(HEADER_WORDS)) begin
      role_nxt = role_t'(pos_r[3:0]);
    end else if (is_data) begin
      role_nxt = ROLE_DATA;
      res_nxt.low_byte  = in_tdata[7:0];
      res_nxt.high_byte = in_tdata[15:8];
      res_nxt.low_byte_valid  =
        {{(COUNT_W-POS_W-1){1'b0}}, rel, 1'b0} < cnt_use;
      res_nxt.high_byte_valid =
        {{(COUNT_W-POS_W-1){1'b0}}, rel, 1'b1} < cnt_use;
    end else begin
      case (trail_idx)
        COUNT_W'(0): role_nxt = ROLE_CABLE_DEST;
        COUNT_W'(1): role_nxt = ROLE_CABLE_SRC;
        COUNT_W'(2): role_nxt = ROLE_CHECK;
        default:     role_nxt = ROLE_EXCESS;
      endcase
    end

    if (in_tlast) begin
      res_nxt.crc_match = (crc_r == in_tdata);
      if (n_words < (POS_W+1)'(HEADER_WORDS + TRAILER_WORDS)) begin
        res_nxt.frame_status = STAT_TOO_SHORT;
      end else if (n_words > (POS_W+1)'(MAX_FRAME_WORDS)) begin
        res_nxt.frame_status = STAT_TOO_LONG;
      end else if (cnt_use > COUNT_W'(MAX_DATA_BYTES)) begin
        res_nxt.frame_status = STAT_COUNT_HIGH;
      end else if ({{(COUNT_W-POS_W-1){1'b0}}, n_words} !=
                   COUNT_W'(HEADER_WORDS + TRAILER_WORDS) + data_wcnt) begin
        res_nxt.frame_status = STAT_LEN_BAD;
      end else begin
        res_nxt.frame_status = STAT_OK;
      end
    end
    last_nxt = in_tlast;
  end

  always_comb begin
    crc_nxt = crc_r;
    pos_nxt = pos_r;
    cnt_nxt = cnt_r;
    if (in_acc) begin
      if (pos_r == POS_W'(1)) begin
        cnt_nxt = in_tdata[COUNT_W-1:0];
      end
      if (in_tlast) begin
        crc_nxt = '0;
        pos_nxt = '0;
      end else begin
        crc_nxt = crc_step;
        if (pos_r != POS_MAX) begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
    end
    out_valid_nxt = in_acc || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      role_r <= role_nxt;
      res_r  <= res_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = role_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {2'b00, res_r};

  a_status_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !last_r |-> res_r.frame_status == STAT_OK && !res_r.crc_match)
    else $error("status or check flag set on a non-final result");

  a_bytes_only_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && role_r != ROLE_DATA |->
      !res_r.low_byte_valid && !res_r.high_byte_valid)
    else $error("byte valid flag on a non-data word");

  a_high_needs_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.high_byte_valid |-> res_r.low_byte_valid)
    else $error("high byte valid without low byte valid");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> pos_r == '0 && crc_r == '0)
    else $error("frame state not cleared after the final word");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(res_r) && $stable(role_r))
    else $error("stalled result changed");

endmodule
